### design/dclp_pkg.sv
// Shared types and constants of the draw command line parser.
// Holds the command and result kind codes, the result record and the hex digit decoder.
// Depends on nothing; every other design file imports it.
`default_nettype none

package dclp_pkg;

  // Character codes the parser reacts to.
  localparam logic [7:0] CHR_NEWLINE = 8'd10;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_F = 8'h66;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_F = 8'h46;
  localparam logic [7:0] CHR_TEXT    = 8'h23;  // '#'
  localparam logic [7:0] CHR_RECT    = 8'h21;  // '!'
  localparam logic [7:0] CHR_FILL    = 8'h24;  // '$'

  // Line layout: numbers are three digits each, the colour four hex digits.
  localparam int DEC_END_FIRST  = 3;
  localparam int DEC_END_SECOND = 6;
  localparam int DEC_END_THIRD  = 9;
  localparam int RECT_DEC_LAST  = 12;
  localparam int RECT_HEX_LAST  = 16;
  localparam int RECT_LINE_LEN  = 17;
  localparam int TEXT_HDR_LAST  = 10;

  localparam int NUM_W    = 16;
  localparam int KIND_W   = 3;
  localparam int TDATA_W  = 88;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_TEXT,
    CMD_RECT,
    CMD_FILL
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TEXT_HEAD,
    KIND_TEXT_BYTE,
    KIND_TEXT_END,
    KIND_RECT,
    KIND_FILL
  } kind_t;

  // Per-line parse state apart from the byte position.
  typedef struct packed {
    cmd_t                       cmd;
    logic [3:0][NUM_W-1:0]      numbers;
    logic [NUM_W-1:0]           colour;
  } line_state_t;

  typedef struct packed {
    kind_t                      kind;
    logic [3:0][NUM_W-1:0]      numbers;
    logic [NUM_W-1:0]           colour;
    logic [7:0]                 text;
    logic                       last;
  } result_t;

  // Value of a hex character; anything else counts as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (b inside {[CHR_ZERO:CHR_NINE]}) begin
        d = b - CHR_ZERO;
      end else if (b inside {[CHR_LOWER_A:CHR_LOWER_F]}) begin
        d = b - CHR_LOWER_A + 8'd10;
      end else if (b inside {[CHR_UPPER_A:CHR_UPPER_F]}) begin
        d = b - CHR_UPPER_A + 8'd10;
      end
      hex_value = d[3:0];
    end
  endfunction

endpackage

`default_nettype wire

### design/dclp_step.sv
// Next-state and result logic of the draw command line parser for one byte.
// Purely combinational; the registers live in draw_command_line_parser.
// Depends on dclp_pkg.
`default_nettype none

module dclp_step #(
  parameter int MAX_LINE = 128,
  parameter int POS_W    = 7
) (
  input  wire logic [7:0]           data_byte,
  input  wire logic [POS_W-1:0]     pos,
  input  wire dclp_pkg::line_state_t state,
  output logic      [POS_W-1:0]     pos_next,
  output dclp_pkg::line_state_t     state_next,
  output logic                      emit,
  output dclp_pkg::result_t         result
);
  import dclp_pkg::*;

  line_state_t       work;
  logic [1:0]        idx;
  logic [NUM_W-1:0]  digit;
  logic [NUM_W-1:0]  acc;
  logic [POS_W:0]    pos_inc;
  logic              restart;
  logic              is_text;
  logic              is_box;

  always_comb begin
    work     = state;
    emit     = 1'b0;
    restart  = 1'b0;
    result   = '0;
    result.kind = KIND_TEXT_HEAD;
    pos_next = pos;
    pos_inc  = {1'b0, pos} + (POS_W+1)'(1);
    is_text  = (state.cmd == CMD_TEXT);
    is_box   = (state.cmd == CMD_RECT) || (state.cmd == CMD_FILL);

    if (pos <= POS_W'(DEC_END_FIRST)) begin
      idx = 2'd0;
    end else if (pos <= POS_W'(DEC_END_SECOND)) begin
      idx = 2'd1;
    end else if (pos <= POS_W'(DEC_END_THIRD)) begin
      idx = 2'd2;
    end else begin
      idx = 2'd3;
    end
    digit = {8'h00, data_byte} - {8'h00, CHR_ZERO};
    acc   = (state.numbers[idx] << 3) + (state.numbers[idx] << 1) + digit;

    if (data_byte == CHR_NEWLINE) begin
      if (pos != '0) begin
        restart = 1'b1;
        if (is_text && pos > POS_W'(TEXT_HDR_LAST)) begin
          emit        = 1'b1;
          result.kind = KIND_TEXT_END;
          result.last = 1'b1;
        end else if (is_box && pos == POS_W'(RECT_LINE_LEN)) begin
          emit        = 1'b1;
          result.kind = (state.cmd == CMD_RECT) ? KIND_RECT : KIND_FILL;
          result.last = 1'b1;
        end
      end
    end else begin
      if (pos == '0) begin
        case (data_byte)
          CHR_TEXT: work.cmd = CMD_TEXT;
          CHR_RECT: work.cmd = CMD_RECT;
          CHR_FILL: work.cmd = CMD_FILL;
          default:  work.cmd = CMD_NONE;
        endcase
      end else if (is_text) begin
        if (pos <= POS_W'(DEC_END_SECOND)) begin
          work.numbers[idx] = acc;
        end else if (pos <= POS_W'(TEXT_HDR_LAST)) begin
          work.colour = {state.colour[NUM_W-5:0], hex_value(data_byte)};
          if (pos == POS_W'(TEXT_HDR_LAST)) begin
            emit        = 1'b1;
            result.kind = KIND_TEXT_HEAD;
          end
        end else begin
          emit        = 1'b1;
          result.kind = KIND_TEXT_BYTE;
          result.text = data_byte;
        end
      end else if (is_box) begin
        if (pos <= POS_W'(RECT_DEC_LAST)) begin
          work.numbers[idx] = acc;
        end else if (pos <= POS_W'(RECT_HEX_LAST)) begin
          work.colour = {state.colour[NUM_W-5:0], hex_value(data_byte)};
        end
      end
      pos_next = pos_inc[POS_W-1:0];
      // A full line closes itself; a result on its last byte ends the line.
      if (pos_inc == (POS_W+1)'(MAX_LINE)) begin
        restart     = 1'b1;
        result.last = emit;
      end
    end

    result.numbers = work.numbers;
    result.colour  = work.colour;

    if (restart) begin
      state_next = '0;
      pos_next   = '0;
    end else begin
      state_next = work;
    end
  end

endmodule

`default_nettype wire

### design/draw_command_line_parser.sv
// Top level of the draw command line parser: byte stream in, draw results out.
// Depends on dclp_pkg and dclp_step.
//
// Usage: serial bytes arrive as transfers on the s_ group (s_tdata holds one
// byte). Bytes are grouped into lines that end at a newline or after MAX_LINE
// bytes; the first byte of a line selects text ('#'), rectangle ('!') or fill
// ('$'). Each input transfer yields zero or one result transfer on the m_ group.
// m_tuser carries the result kind, m_tlast marks the result that closes a line,
// and m_tdata carries the four numbers, the colour and the text byte.
//
// A result is visible on m_ the cycle after its byte is taken. Throughput is
// one byte per cycle unless the receiver stalls, set by the single result
// register that follows the one-byte parse logic in dclp_step. s_tready stays
// high while the result register is empty or being drained, so a new byte is
// taken in the same cycle a waiting result leaves. When the receiver stalls
// with a result held, s_tready drops and the byte stream waits; bytes that
// produce no result still need a free result register. Reset clears the line
// position, the command, the numbers and colour, and empties the result register.
`default_nettype none

module draw_command_line_parser #(
  parameter int MAX_LINE = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // [7:0] data_byte
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [15:0] first_number, [31:16] second_number, [47:32] third_number,
  // [63:48] fourth_number, [79:64] colour_word, [87:80] text_byte
  output logic [dclp_pkg::TDATA_W-1:0]       m_tdata,
  output logic [dclp_pkg::KIND_W-1:0]        m_tuser,   // [2:0] kind
  output logic                               m_tlast    // line_end
);
  import dclp_pkg::*;

  localparam int POS_W = $clog2(MAX_LINE);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  line_state_t      state;
  line_state_t      state_next;
  logic             emit;
  result_t          result;
  result_t          out_reg;
  logic             accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  dclp_step #(
    .MAX_LINE (MAX_LINE),
    .POS_W    (POS_W)
  ) u_step (
    .data_byte  (s_tdata),
    .pos        (pos),
    .state      (state),
    .pos_next   (pos_next),
    .state_next (state_next),
    .emit       (emit),
    .result     (result)
  );

  // Line state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      state <= '0;
    end else if (accept) begin
      pos   <= pos_next;
      state <= state_next;
    end
  end

  // Result register: loaded by an accepted byte, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {out_reg.text, out_reg.colour, out_reg.numbers[3], out_reg.numbers[2],
                    out_reg.numbers[1], out_reg.numbers[0]};
  assign m_tuser = out_reg.kind;
  assign m_tlast = out_reg.last;

endmodule

`default_nettype wire

### design/dclp_checker.sv
// Port-level checks for draw_command_line_parser and the bind that attaches them.
// Depends on dclp_pkg; sees only the top-level ports.
`default_nettype none

module dclp_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [dclp_pkg::TDATA_W-1:0]  m_tdata,
  input wire logic [dclp_pkg::KIND_W-1:0]   m_tuser,
  input wire logic                          m_tlast
);
  import dclp_pkg::*;

  // A held result does not change while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // An empty result register never blocks the byte stream.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // Only text byte results carry a character.
  a_text: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_TEXT_BYTE |-> m_tdata[TDATA_W-1:TDATA_W-8] == 8'h00)
    else $error("text byte set on a non-text result");

  // Text end, rectangle and fill always close their line; a header never does.
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_TEXT_END || m_tuser == KIND_RECT || m_tuser == KIND_FILL)
      |-> m_tlast)
    else $error("closing result without line end");

  a_head: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_TEXT_HEAD |-> !m_tlast)
    else $error("text header marked as line end");

endmodule

bind draw_command_line_parser dclp_checker u_dclp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
